// ----- sv/kmer_specificity_histogram_unit_macros.svh -----
// Assertion macros shared by the histogram unit.
`ifndef KMER_SPECIFICITY_HISTOGRAM_UNIT_MACROS_SVH
`define KMER_SPECIFICITY_HISTOGRAM_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KSH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("histogram unit: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define KSH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("histogram unit: next-cycle check failed");

`endif

// ----- sv/kshist_pkg.sv -----
package kshist_pkg;

    localparam int COV_LIMIT     = 255;
    localparam int COUNTER_WIDTH = 32;

    localparam int NUM_BINS  = 6;
    localparam int COLS      = COV_LIMIT + 1;
    localparam int DEPTH     = NUM_BINS * COLS;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int COL_W     = $clog2(COLS);
    localparam int BIN_W     = 3;
    localparam int FCNT_W    = 16;
    localparam int TOTAL_W   = FCNT_W + 1;
    localparam int COV_W     = 8;
    localparam int OUT_CNT_W = 32;
    localparam int BOUND_W   = 7;
    localparam int PROD_W    = TOTAL_W + BOUND_W;
    localparam int PCT_SCALE = 100;

    typedef logic [BOUND_W-1:0] t_bound;
    localparam t_bound BOUNDS [NUM_BINS] = '{
        t_bound'(70), t_bound'(85), t_bound'(90),
        t_bound'(95), t_bound'(99), t_bound'(101)
    };

    typedef logic [COUNTER_WIDTH-1:0] t_counter;
    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [BIN_W-1:0]         t_bin;
    typedef logic [TOTAL_W-1:0]       t_total;
    typedef logic [FCNT_W-1:0]        t_fcnt;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_ZERO  = 2'd1,
        STAT_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        t_op              op;
        logic [15:0]      first_count;
        logic [15:0]      second_count;
        logic [2:0]       read_bin;
        logic [COV_W-1:0] read_coverage;
    } t_in_word;

    typedef struct packed {
        logic [2:0]           bin_index;
        logic [OUT_CNT_W-1:0] bin_count;
        t_status              status;
    } t_out_word;

endpackage

// ----- sv/kshist_bin_pick.sv -----
module kshist_bin_pick
    import kshist_pkg::*;
(
    input  t_total i_total,
    input  t_fcnt  i_larger,
    output t_bin   o_bin
);

    logic [PROD_W-1:0]   w_lhs;
    logic [NUM_BINS-2:0] w_below;

    assign w_lhs = PROD_W'(i_larger) * PROD_W'(PCT_SCALE);

    always_comb begin
        for (int b = 0; b < NUM_BINS - 1; b++) begin
            w_below[b] = w_lhs < (PROD_W'(i_total) * PROD_W'(BOUNDS[b]));
        end
    end

    // first bound that the scaled ratio stays under
    always_comb begin
        o_bin = BIN_W'(NUM_BINS - 1);
        for (int b = NUM_BINS - 2; b >= 0; b--) begin
            if (w_below[b]) begin
                o_bin = BIN_W'(b);
            end
        end
    end

endmodule

// ----- sv/kmer_specificity_histogram_unit.sv -----
// Each input word passes the bin, read and modify states (bin compare, counter
// read, modify-write) before its result word is registered; no new word is
// accepted until then, set by the single read-modify-write pass through the
// counter memory. Reset: synchronous, active low; afterwards a clearing pass
// writes zero to all 1536 counters, one per cycle; input stays stalled meanwhile.
`include "kmer_specificity_histogram_unit_macros.svh"

module kmer_specificity_histogram_unit
    import kshist_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BIN,
        ST_RD,
        ST_MOD
    } t_state;

    t_state     r_state;
    t_addr      r_clr_addr;
    t_op        r_op;
    logic [2:0] r_rbin;
    logic [COV_W-1:0] r_rcov;
    t_total     r_total;
    t_fcnt      r_larger;
    t_bin       r_bin;
    t_addr      r_addr;
    logic       r_hit;
    t_status    r_status;
    t_counter   r_rdata;
    logic       r_out_valid;
    t_out_word  r_out_word;

    t_counter   r_store [DEPTH];

    t_bin       w_pick;
    t_bin       n_bin;
    t_addr      n_addr;
    logic       n_hit;
    t_status    n_status;
    t_counter   n_count;
    logic       n_out_valid;
    logic       w_in_accept;
    logic       w_out_free;
    logic       w_mod_go;
    logic       w_mem_we;
    t_addr      w_mem_waddr;
    t_counter   w_mem_wdata;

    kshist_bin_pick u_bin_pick (
        .i_total  (r_total),
        .i_larger (r_larger),
        .o_bin    (w_pick)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_mod_go    = (r_state == ST_MOD) && w_out_free;
    assign n_out_valid = w_mod_go || (r_out_valid && i_out_stall);

    always_comb begin
        n_bin    = '0;
        n_addr   = '0;
        n_hit    = 1'b0;
        n_status = STAT_OK;
        if (r_op == OP_ADD) begin
            if (r_total == '0) begin
                n_status = STAT_ZERO;
            end else begin
                n_bin = w_pick;
                if (int'(r_total) > COV_LIMIT) begin
                    n_status = STAT_RANGE;
                end else begin
                    n_hit  = 1'b1;
                    n_addr = ADDR_W'(int'(w_pick) * COLS + int'(COL_W'(r_total)));
                end
            end
        end else begin
            n_bin = BIN_W'(r_rbin);
            if (int'(r_rcov) > COV_LIMIT) begin
                n_status = STAT_RANGE;
            end else if (int'(r_rbin) < NUM_BINS) begin
                n_hit  = 1'b1;
                n_addr = ADDR_W'(int'(r_rbin) * COLS + int'(COL_W'(r_rcov)));
            end
        end
    end

    // saturating increment on add, plain read otherwise
    always_comb begin
        n_count = '0;
        if (r_hit) begin
            if (r_op == OP_ADD && r_rdata != '1) begin
                n_count = r_rdata + t_counter'(1);
            end else begin
                n_count = r_rdata;
            end
        end
    end

    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = r_addr;
        w_mem_wdata = n_count;
        if (r_state == ST_CLEAR) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = r_clr_addr;
            w_mem_wdata = '0;
        end else if (w_mod_go && r_hit && r_op == OP_ADD) begin
            w_mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_store[w_mem_waddr] <= w_mem_wdata;
        end
        r_rdata <= r_store[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                ST_CLEAR: begin
                    if (int'(r_clr_addr) == DEPTH - 1) begin
                        r_state <= ST_IDLE;
                    end
                    r_clr_addr <= r_clr_addr + t_addr'(1);
                end
                ST_IDLE: begin
                    if (w_in_accept) begin
                        r_state <= ST_BIN;
                    end
                end
                ST_BIN: begin
                    r_state <= ST_RD;
                end
                ST_RD: begin
                    r_state <= ST_MOD;
                end
                ST_MOD: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_op     <= i_in_word.op;
            r_rbin   <= i_in_word.read_bin;
            r_rcov   <= i_in_word.read_coverage;
            r_total  <= TOTAL_W'(i_in_word.first_count) + TOTAL_W'(i_in_word.second_count);
            r_larger <= (i_in_word.first_count > i_in_word.second_count) ?
                        i_in_word.first_count : i_in_word.second_count;
        end
        if (r_state == ST_BIN) begin
            r_bin    <= n_bin;
            r_addr   <= n_addr;
            r_hit    <= n_hit;
            r_status <= n_status;
        end
        if (w_mod_go) begin
            r_out_word.bin_index <= r_bin;
            r_out_word.bin_count <= OUT_CNT_W'(n_count);
            r_out_word.status    <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `KSH_ASSERT_NEXT(a_accept_enters_bin, i_clk, i_rst_n, w_in_accept, r_state == ST_BIN)
    `KSH_ASSERT_NEXT(a_clear_done_idle, i_clk, i_rst_n, (r_state == ST_CLEAR) && (int'(r_clr_addr) == DEPTH - 1), r_state == ST_IDLE)
    `KSH_ASSERT_SAME(a_zero_total_empty, i_clk, i_rst_n, o_out_valid && (o_out_word.status == STAT_ZERO), (o_out_word.bin_count == '0) && (o_out_word.bin_index == '0))
    `KSH_ASSERT_SAME(a_range_no_count, i_clk, i_rst_n, o_out_valid && (o_out_word.status == STAT_RANGE), o_out_word.bin_count == '0)

endmodule
